### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define IFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define IFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/ifr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifr_pkg;

  localparam int unsigned FRAME_LEN  = 15;
  localparam int unsigned SUM_POS    = 14;
  localparam int unsigned FIRST_BODY = 2;
  localparam int unsigned LAST_BODY  = 13;
  localparam int unsigned CNT_W      = 4;

  localparam logic [7:0] HDR_SYNC = 8'hAA;
  localparam logic [7:0] HDR_ZERO = 8'h00;
  localparam logic [7:0] TAG_NORMAL  = 8'hEE;
  localparam logic [7:0] TAG_STANDBY = 8'hFF;
  localparam logic [7:0] TAG_SLEEP   = 8'hDD;

  localparam logic [16:0] ANGLE_WRAP = 17'd36000;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NORMAL  = 2'd0;
  localparam mode_t MODE_STANDBY = 2'd1;
  localparam mode_t MODE_SLEEP   = 2'd2;

  typedef enum logic [2:0] {
    STS_COLLECT   = 3'd0,
    STS_HDR_DROP  = 3'd1,
    STS_SUM_FAIL  = 3'd2,
    STS_DATA      = 3'd3,
    STS_ACK_NORM  = 3'd4,
    STS_ACK_STBY  = 3'd5,
    STS_ACK_SLEEP = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;
  } dp_status_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        angle;
    logic signed [15:0] rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [7:0]         frame_index;
    logic [7:0]         calibration;
    logic               data_valid;
    logic               is_good;
    mode_t              remote_mode;
  } result_t;

endpackage

`default_nettype wire

### hdl/ifr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ifr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        angle;
  logic signed [15:0] rate;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [7:0]         frame_index;
  logic [7:0]         calibration;
  logic               data_valid;
  logic               is_good;
  logic [1:0]         remote_mode;

  modport source (output valid, output status, output angle, output rate,
                  output accel_x, output accel_y, output accel_z,
                  output frame_index, output calibration, output data_valid,
                  output is_good, output remote_mode, input ready);
  modport sink   (input valid, input status, input angle, input rate,
                  input accel_x, input accel_y, input accel_z,
                  input frame_index, input calibration, input data_valid,
                  input is_good, input remote_mode, output ready);
endinterface

interface ifr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] requested_mode;

  modport source (output valid, output requested_mode, input ready);
  modport sink   (input valid, input requested_mode, output ready);
endinterface

`default_nettype wire

### hdl/imu_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload
// in_bus   sink       rx_byte
// out_bus  source     status, angle, rate, accel_x/y/z, frame_index,
//                     calibration, data_valid, is_good, remote_mode
// cfg_bus  sink       requested_mode (always ready)
//
// An ordinary byte is accepted in ST_IDLE, then its result register is offered in ST_OUT.
// The byte that completes a frame also passes through ST_FINISH between them, the
// finish step for checksum, control decode and angle remap.
// One item at a time: in_bus is not ready while a result waits on out_bus.
// Reset is synchronous, active low; the frame count and held values clear.

module imu_frame_receiver (
  input wire        clk,
  input wire        rst_n,
  ifr_in_if.sink    in_bus,
  ifr_out_if.source out_bus,
  ifr_cfg_if.sink   cfg_bus
);
  import ifr_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t    cmd;
  dp_status_t st;
  result_t    res;

  ifr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .out_ready (out_bus.ready),
    .st        (st),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .cmd       (cmd)
  );

  ifr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .rx_byte  (in_bus.rx_byte),
    .cfg_we   (cfg_bus.valid),
    .cfg_mode (cfg_bus.requested_mode),
    .st       (st),
    .res      (res)
  );

  assign cfg_bus.ready = 1'b1;

  assign out_bus.status      = res.status;
  assign out_bus.angle       = res.angle;
  assign out_bus.rate        = res.rate;
  assign out_bus.accel_x     = res.accel_x;
  assign out_bus.accel_y     = res.accel_y;
  assign out_bus.accel_z     = res.accel_z;
  assign out_bus.frame_index = res.frame_index;
  assign out_bus.calibration = res.calibration;
  assign out_bus.data_valid  = res.data_valid;
  assign out_bus.is_good     = res.is_good;
  assign out_bus.remote_mode = res.remote_mode;

  `IFR_ASSERT_IMP(a_no_accept_while_offering, clk, rst_n, in_bus.valid && in_bus.ready, !out_bus.valid)
  `IFR_ASSERT_IMP(a_data_sets_seen, clk, rst_n, out_bus.valid && (out_bus.status == STS_DATA), out_bus.data_valid)
  `IFR_ASSERT_IMP(a_ack_clears_good, clk, rst_n, out_bus.valid && ((out_bus.status == STS_ACK_STBY) || (out_bus.status == STS_ACK_SLEEP)), !out_bus.is_good)
  `IFR_ASSERT_IMP(a_idx_zero_off_data, clk, rst_n, out_bus.valid && (out_bus.status != STS_DATA), (out_bus.frame_index == 8'h00) && (out_bus.calibration == 8'h00))
  `IFR_ASSERT_NEXT(a_result_follows_item, clk, rst_n, in_bus.valid && in_bus.ready && !st.frame_end, out_bus.valid)

endmodule

`default_nettype wire

### hdl/ifr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ifr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 out_ready,
  input  ifr_pkg::dp_status_t st,
  output logic                in_ready,
  output logic                out_valid,
  output ifr_pkg::dp_cmd_t    cmd
);
  import ifr_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = st.frame_end ? ST_FINISH : ST_OUT;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/ifr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ifr_dp (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ifr_pkg::dp_cmd_t    cmd,
  input  wire [7:0]           rx_byte,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_mode,
  output ifr_pkg::dp_status_t st,
  output ifr_pkg::result_t    res
);
  import ifr_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       body_r [FIRST_BODY:LAST_BODY];
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  mode_t            req_r, req_nxt;
  mode_t            acked_r, acked_nxt;
  logic             good_r, good_nxt;
  logic             seen_r, seen_nxt;
  logic [15:0]      angle_r, angle_nxt;
  logic [15:0]      rate_r, rate_nxt;
  logic [15:0]      ax_r, ax_nxt;
  logic [15:0]      ay_r, ay_nxt;
  logic [15:0]      az_r, az_nxt;
  status_t          status_r, status_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [7:0]       cal_r, cal_nxt;

  logic             hdr_bad;
  logic             ctl_frame;
  logic             zero_run;
  logic [7:0]       tag;
  logic [16:0]      angle_raw;
  logic [15:0]      raw_angle;

  assign st.frame_end = (count_r == CNT_W'(SUM_POS));

  assign hdr_bad = ((count_r == CNT_W'(0)) && (rx_byte != HDR_SYNC)) ||
                   ((count_r == CNT_W'(1)) && (rx_byte != HDR_ZERO));

  assign tag      = body_r[5];
  assign zero_run = (body_r[2] == 8'h00) && (body_r[3] == 8'h00) &&
                    (body_r[4] == 8'h00) && (body_r[8] == 8'h00) &&
                    (body_r[9] == 8'h00) && (body_r[10] == 8'h00) &&
                    (body_r[11] == 8'h00) && (body_r[12] == 8'h00) &&
                    (body_r[13] == 8'h00);
  assign ctl_frame = zero_run && (body_r[6] == tag) && (body_r[7] == tag) &&
                     (tag inside {TAG_NORMAL, TAG_STANDBY, TAG_SLEEP});

  assign raw_angle = {body_r[4], body_r[3]};
  assign angle_raw = ANGLE_WRAP - {raw_angle[15], raw_angle};

  always_comb begin
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    chk_nxt    = chk_r;
    req_nxt    = cfg_we ? cfg_mode : req_r;
    acked_nxt  = acked_r;
    good_nxt   = good_r;
    seen_nxt   = seen_r;
    angle_nxt  = angle_r;
    rate_nxt   = rate_r;
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    az_nxt     = az_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    cal_nxt    = cal_r;

    if (cmd.load) begin
      status_nxt = STS_COLLECT;
      idx_nxt    = 8'h00;
      cal_nxt    = 8'h00;
      if (hdr_bad) begin
        status_nxt = STS_HDR_DROP;
        count_nxt  = '0;
      end else if (count_r == CNT_W'(SUM_POS)) begin
        chk_nxt   = rx_byte;
        count_nxt = '0;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == CNT_W'(0)) begin
          sum_nxt = 8'h00;
        end else if (count_r >= CNT_W'(FIRST_BODY)) begin
          sum_nxt = sum_r + rx_byte;
        end
      end
    end

    if (cmd.finish) begin
      if (chk_r != sum_r) begin
        status_nxt = STS_SUM_FAIL;
      end else if (ctl_frame) begin
        case (tag)
          TAG_NORMAL: begin
            acked_nxt  = MODE_NORMAL;
            status_nxt = STS_ACK_NORM;
          end
          TAG_STANDBY: begin
            acked_nxt  = MODE_STANDBY;
            good_nxt   = 1'b0;
            status_nxt = STS_ACK_STBY;
          end
          default: begin
            acked_nxt  = MODE_SLEEP;
            good_nxt   = 1'b0;
            status_nxt = STS_ACK_SLEEP;
          end
        endcase
      end else begin
        angle_nxt  = (angle_raw >= ANGLE_WRAP) ? 16'(angle_raw - ANGLE_WRAP)
                                               : angle_raw[15:0];
        rate_nxt   = 16'h0000 - {body_r[6], body_r[5]};
        ay_nxt     = {body_r[8], body_r[7]};
        ax_nxt     = 16'h0000 - {body_r[10], body_r[9]};
        az_nxt     = 16'h0000 - {body_r[12], body_r[11]};
        if (req_r == MODE_NORMAL) begin
          good_nxt = 1'b1;
        end
        seen_nxt   = 1'b1;
        idx_nxt    = body_r[2];
        cal_nxt    = body_r[13];
        status_nxt = STS_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      req_r    <= MODE_STANDBY;
      acked_r  <= MODE_STANDBY;
      good_r   <= 1'b0;
      seen_r   <= 1'b0;
      angle_r  <= '0;
      rate_r   <= '0;
      ax_r     <= '0;
      ay_r     <= '0;
      az_r     <= '0;
      status_r <= STS_COLLECT;
      idx_r    <= '0;
      cal_r    <= '0;
    end else begin
      count_r  <= count_nxt;
      req_r    <= req_nxt;
      acked_r  <= acked_nxt;
      good_r   <= good_nxt;
      seen_r   <= seen_nxt;
      angle_r  <= angle_nxt;
      rate_r   <= rate_nxt;
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      az_r     <= az_nxt;
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      cal_r    <= cal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    chk_r <= chk_nxt;
  end

  for (genvar i = FIRST_BODY; i <= LAST_BODY; i++) begin : g_body
    always_ff @(posedge clk) begin
      if (cmd.load && !hdr_bad && (count_r == CNT_W'(i))) begin
        body_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    res.status      = status_r;
    res.angle       = angle_r;
    res.rate        = rate_r;
    res.accel_x     = ax_r;
    res.accel_y     = ay_r;
    res.accel_z     = az_r;
    res.frame_index = idx_r;
    res.calibration = cal_r;
    res.data_valid  = seen_r;
    res.is_good     = good_r;
    res.remote_mode = acked_r;
  end

endmodule

`default_nettype wire

### tb/frame_checker.sv
`timescale 1ns / 1ps

module frame_checker
  import ifr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ifr_in_if    in_bus,
  ifr_out_if   out_bus,
  ifr_cfg_if   cfg_bus,
  output int   failures,
  output int   outstanding
);

  logic [7:0]  frame_bytes [FRAME_LEN];
  logic [3:0]  fill;
  mode_t       req_mode;
  mode_t       acked;
  logic        good;
  logic        seen;
  logic [15:0] held_angle;
  logic [15:0] held_rate;
  logic [15:0] held_ax;
  logic [15:0] held_ay;
  logic [15:0] held_az;
  result_t     expected_results [$];
  result_t     next_result;
  result_t     oldest;

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  task automatic flag_error(input string what);
    if (failures < 60) begin
      $display("%0t: %s", $time, what);
    end
    failures++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] wanted);
    if (got !== wanted) begin
      flag_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, wanted));
    end
  endtask

  function automatic logic [15:0] word_at(input int pos);
    return {frame_bytes[pos + 1], frame_bytes[pos]};
  endfunction

  function automatic logic is_control();
    logic [7:0] tag;
    tag = frame_bytes[5];
    for (int i = FIRST_BODY; i < 5; i++) begin
      if (frame_bytes[i] != 8'h00) return 1'b0;
    end
    if (tag != TAG_NORMAL && tag != TAG_STANDBY && tag != TAG_SLEEP) return 1'b0;
    if (frame_bytes[6] != tag || frame_bytes[7] != tag) return 1'b0;
    for (int i = 8; i <= LAST_BODY; i++) begin
      if (frame_bytes[i] != 8'h00) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, output result_t r);
    int         pos;
    int         wrapped;
    logic [7:0] sum;
    logic [7:0] idx;
    logic [7:0] cal;
    status_t    st;
    st  = STS_COLLECT;
    idx = 8'h00;
    cal = 8'h00;
    pos = int'(fill);
    frame_bytes[pos] = b;
    pos++;
    if (frame_bytes[0] != HDR_SYNC || (pos >= 2 && frame_bytes[1] != HDR_ZERO)) begin
      st  = STS_HDR_DROP;
      pos = 0;
    end else if (pos == FRAME_LEN) begin
      sum = 8'h00;
      for (int i = FIRST_BODY; i <= LAST_BODY; i++) sum = sum + frame_bytes[i];
      if (frame_bytes[SUM_POS] != sum) begin
        st = STS_SUM_FAIL;
      end else if (is_control()) begin
        if (frame_bytes[5] == TAG_NORMAL) begin
          acked = MODE_NORMAL;
          st    = STS_ACK_NORM;
        end else if (frame_bytes[5] == TAG_STANDBY) begin
          acked = MODE_STANDBY;
          good  = 1'b0;
          st    = STS_ACK_STBY;
        end else begin
          acked = MODE_SLEEP;
          good  = 1'b0;
          st    = STS_ACK_SLEEP;
        end
      end else begin
        wrapped = int'(ANGLE_WRAP) - int'($signed(word_at(3)));
        if (wrapped >= int'(ANGLE_WRAP)) wrapped = wrapped - int'(ANGLE_WRAP);
        held_angle = wrapped[15:0];
        held_rate  = 16'h0000 - word_at(5);
        held_ay    = word_at(7);
        held_ax    = 16'h0000 - word_at(9);
        held_az    = 16'h0000 - word_at(11);
        if (req_mode == MODE_NORMAL) good = 1'b1;
        seen = 1'b1;
        idx  = frame_bytes[FIRST_BODY];
        cal  = frame_bytes[LAST_BODY];
        st   = STS_DATA;
      end
      pos = 0;
    end
    fill = pos[3:0];
    r.status      = st;
    r.angle       = held_angle;
    r.rate        = held_rate;
    r.accel_x     = held_ax;
    r.accel_y     = held_ay;
    r.accel_z     = held_az;
    r.frame_index = idx;
    r.calibration = cal;
    r.data_valid  = seen;
    r.is_good     = good;
    r.remote_mode = acked;
  endtask

  task automatic compare_result(input result_t w);
    check_field("status", 16'(out_bus.status), 16'(w.status));
    check_field("angle", out_bus.angle, w.angle);
    check_field("rate", out_bus.rate, w.rate);
    check_field("accel_x", out_bus.accel_x, w.accel_x);
    check_field("accel_y", out_bus.accel_y, w.accel_y);
    check_field("accel_z", out_bus.accel_z, w.accel_z);
    check_field("frame_index", 16'(out_bus.frame_index), 16'(w.frame_index));
    check_field("calibration", 16'(out_bus.calibration), 16'(w.calibration));
    check_field("data_valid", 16'(out_bus.data_valid), 16'(w.data_valid));
    check_field("is_good", 16'(out_bus.is_good), 16'(w.is_good));
    check_field("remote_mode", 16'(out_bus.remote_mode), 16'(w.remote_mode));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill       = 4'd0;
      req_mode   = MODE_STANDBY;
      acked      = MODE_STANDBY;
      good       = 1'b0;
      seen       = 1'b0;
      held_angle = 16'h0000;
      held_rate  = 16'h0000;
      held_ax    = 16'h0000;
      held_ay    = 16'h0000;
      held_az    = 16'h0000;
      expected_results.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) req_mode = cfg_bus.requested_mode;
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          flag_error("result item arrived with no byte outstanding");
        end else begin
          oldest = expected_results.pop_front();
          compare_result(oldest);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        absorb_byte(in_bus.rx_byte, next_result);
        expected_results.push_back(next_result);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ifr_pkg::*;

  localparam int    CYCLE_LIMIT   = 200000;
  localparam int    SEGMENT_BYTES = 220;
  localparam mode_t MODE_UNUSED   = 2'd3;
  localparam mode_t SEG_MODE [6]  = '{MODE_NORMAL, MODE_SLEEP, MODE_UNUSED,
                                      MODE_STANDBY, MODE_NORMAL, MODE_SLEEP};

  logic       clk = 1'b0;
  logic       rst_n;
  int         failures;
  int         outstanding;
  int         cycle_count = 0;
  int         bytes_sent;
  int         send_idle;
  int         recv_idle;
  int         stall_left;
  logic [7:0] pkt [FRAME_LEN];

  ifr_in_if  in_ch ();
  ifr_out_if out_ch ();
  ifr_cfg_if cfg_ch ();

  imu_frame_receiver dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  frame_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_ch),
    .out_bus    (out_ch),
    .cfg_bus    (cfg_ch),
    .failures   (failures),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("imu_frame_receiver test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_packet(input int count);
    for (int i = 0; i < count; i++) send_byte(pkt[i]);
  endtask

  task automatic seal_packet();
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = FIRST_BODY; i <= LAST_BODY; i++) sum = sum + pkt[i];
    pkt[SUM_POS] = sum;
  endtask

  task automatic build_data(input logic [15:0] raw_angle);
    pkt[0] = HDR_SYNC;
    pkt[1] = HDR_ZERO;
    for (int i = FIRST_BODY; i <= LAST_BODY; i++) pkt[i] = 8'($urandom_range(255));
    pkt[3] = raw_angle[7:0];
    pkt[4] = raw_angle[15:8];
    seal_packet();
  endtask

  task automatic build_control(input logic [7:0] tag);
    pkt[0] = HDR_SYNC;
    pkt[1] = HDR_ZERO;
    for (int i = FIRST_BODY; i <= LAST_BODY; i++) pkt[i] = 8'h00;
    pkt[5] = tag;
    pkt[6] = tag;
    pkt[7] = tag;
    seal_packet();
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] pick_tag();
    case ($urandom_range(2))
      0:       return TAG_NORMAL;
      1:       return TAG_STANDBY;
      default: return TAG_SLEEP;
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.requested_mode <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_segment(input int quota);
    int start;
    int kind;
    int k;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        build_data(pick_angle());
        send_packet(FRAME_LEN);
      end else if (kind < 65) begin
        build_control(pick_tag());
        if ($urandom_range(3) == 0) begin
          k      = $urandom_range(LAST_BODY, FIRST_BODY);
          pkt[k] = pkt[k] ^ 8'($urandom_range(255, 1));
          seal_packet();
        end
        send_packet(FRAME_LEN);
      end else if (kind < 75) begin
        if ($urandom_range(1) == 0) build_data(pick_angle());
        else build_control(pick_tag());
        pkt[SUM_POS] = pkt[SUM_POS] ^ 8'($urandom_range(255, 1));
        send_packet(FRAME_LEN);
      end else if (kind < 85) begin
        k = $urandom_range(4, 1);
        repeat (k) begin
          if ($urandom_range(1) == 0) begin
            send_byte(8'($urandom_range(255)));
          end else begin
            send_byte(HDR_SYNC);
            send_byte(8'($urandom_range(255, 1)));
          end
        end
      end else begin
        build_data(pick_angle());
        send_packet($urandom_range(FRAME_LEN - 1, 2));
      end
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.rx_byte         = 8'h00;
    cfg_ch.valid          = 1'b0;
    cfg_ch.requested_mode = MODE_STANDBY;
    out_ch.ready          = 1'b0;
    send_idle             = 36;
    recv_idle             = 58;
    stall_left            = 0;
    bytes_sent            = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_NORMAL);
    send_byte(8'h55);
    send_byte(HDR_SYNC);
    send_byte(8'h01);
    build_data(16'h8000);
    pkt[2]  = 8'hFF;
    pkt[5]  = 8'h00;
    pkt[6]  = 8'h80;
    pkt[9]  = 8'h00;
    pkt[10] = 8'h80;
    pkt[11] = 8'hFF;
    pkt[12] = 8'h7F;
    pkt[13] = 8'hFF;
    seal_packet();
    send_packet(FRAME_LEN);
    build_control(TAG_STANDBY);
    send_packet(FRAME_LEN);
    build_control(TAG_NORMAL);
    pkt[SUM_POS] = pkt[SUM_POS] ^ 8'h01;
    send_packet(FRAME_LEN);
    build_data(16'hFFFF);
    send_packet(FRAME_LEN);

    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      write_mode(SEG_MODE[seg]);
      if (seg < 2) begin
        send_idle = 36;
        recv_idle = 58;
      end else if (seg < 4) begin
        send_idle = 58;
        recv_idle = 36;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (seg == 1) stall_left <= 400;
      if (seg == 3) begin
        run_segment(SEGMENT_BYTES / 2);
        wait_drained();
        run_segment(SEGMENT_BYTES / 2);
      end else begin
        run_segment(SEGMENT_BYTES);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("imu_frame_receiver test passed");
    end else begin
      $display("imu_frame_receiver test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/ifr_pkg.sv
hdl/ifr_if.sv
hdl/ifr_ctrl.sv
hdl/ifr_dp.sv
hdl/imu_frame_receiver.sv
tb/frame_checker.sv
tb/testbench.sv
